// ===== sv/mme_pkg.sv =====
// shared types, codes and sizes of the matrix multiply engine
package mme_pkg;

  localparam int MaxDim     = 8;
  localparam int IdxW       = $clog2(MaxDim);
  localparam int AddrW      = 2 * IdxW;
  localparam int StoreDepth = MaxDim * MaxDim;
  localparam int ElemW      = 16;
  localparam int DimW       = 4;
  localparam int ProdW      = 2 * ElemW;
  localparam int AccW       = ProdW + IdxW + 1;
  localparam int OutW       = 40;
  localparam int InDataW    = 24;
  localparam int OutDataW   = 48;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  localparam logic [1:0] REQ_LOAD_A  = 2'd0;
  localparam logic [1:0] REQ_LOAD_B  = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  localparam logic [1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [1:0] CFG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD_A  = 2'd0,
    KIND_LOAD_B  = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [IdxW-1:0]         row;
    logic [IdxW-1:0]         col;
    logic signed [ElemW-1:0] value;
  } work_t;

  // last index in use along each dimension
  typedef struct packed {
    logic [IdxW-1:0] n_last;
    logic [IdxW-1:0] m_last;
    logic [IdxW-1:0] p_last;
  } dims_t;

endpackage

// ===== sv/mme_ram.sv =====
// generic single write, single registered read ram
module mme_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mme_front.sv =====
// input side: accepts items, classifies them and queues work for the back end
module mme_front import mme_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [InDataW-1:0] s_tdata,
  input  logic [1:0]         s_tuser,
  output logic               q_valid,
  output work_t              q_item,
  input  logic               q_pop
);

  work_t            entries [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   count;
  logic             keep;
  work_t            item_in;
  logic             push;

  always_comb begin
    keep         = 1'b1;
    item_in.kind = KIND_LOAD_A;
    unique case (s_tuser)
      REQ_LOAD_A:  item_in.kind = KIND_LOAD_A;
      REQ_LOAD_B:  item_in.kind = KIND_LOAD_B;
      REQ_COMPUTE: item_in.kind = KIND_COMPUTE;
      REQ_NONE:    keep = 1'b0;
      default:     keep = 1'b0;
    endcase
    item_in.row   = s_tdata[IdxW-1:0];
    item_in.col   = s_tdata[2*IdxW-1:IdxW];
    item_in.value = s_tdata[2*IdxW+ElemW-1:2*IdxW];
  end

  assign s_tready = (count != (QPtrW+1)'(QueueDepth));
  assign push     = s_tvalid && s_tready && keep;
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/mme_back.sv =====
// back end: element stores, multiply-accumulate sequencer and result register
module mme_back import mme_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dims_t               dims,
  input  logic                q_valid,
  input  work_t               q_item,
  output logic                q_pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  typedef struct packed {
    logic            valid;
    logic            first;
    logic            last_k;
    logic            last_el;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } tag_t;

  state_t state, state_next;
  logic [IdxW-1:0] i_idx, i_next;
  logic [IdxW-1:0] j_idx, j_next;
  logic [IdxW-1:0] k_idx, k_next;

  logic             a_we, b_we;
  logic [AddrW-1:0] waddr, a_raddr, b_raddr;
  logic [ElemW-1:0] a_rdata, b_rdata;

  tag_t issue, s1, s2;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc;
  logic signed [AccW-1:0]  sum;
  logic                    land;

  logic [IdxW-1:0]         res_row, res_col;
  logic signed [OutW-1:0]  res_value;
  logic                    res_last;

  assign waddr   = {q_item.row, q_item.col};
  assign a_raddr = {i_idx, k_idx};
  assign b_raddr = {k_idx, j_idx};
  assign q_pop   = (state == ST_IDLE) && q_valid;
  assign a_we    = q_pop && (q_item.kind == KIND_LOAD_A);
  assign b_we    = q_pop && (q_item.kind == KIND_LOAD_B);

  mme_ram #(.Width(ElemW), .Depth(StoreDepth)) u_store_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (q_item.value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mme_ram #(.Width(ElemW), .Depth(StoreDepth)) u_store_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (q_item.value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign land = s2.valid && s2.last_k;

  always_comb begin
    state_next    = state;
    i_next        = i_idx;
    j_next        = j_idx;
    k_next        = k_idx;
    issue         = '0;
    issue.first   = (k_idx == '0);
    issue.last_k  = (k_idx == dims.m_last);
    issue.last_el = (i_idx == dims.n_last) && (j_idx == dims.p_last);
    issue.row     = i_idx;
    issue.col     = j_idx;
    unique case (state)
      ST_IDLE: begin
        if (q_pop && (q_item.kind == KIND_COMPUTE)) begin
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        // a new element waits until the result register is free
        if (!(issue.first && m_tvalid)) begin
          issue.valid = 1'b1;
          if (issue.last_k) begin
            k_next     = '0;
            state_next = ST_WAIT;
          end else begin
            k_next = k_idx + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (land) begin
          if (issue.last_el) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_RUN;
            if (j_idx == dims.p_last) begin
              j_next = '0;
              i_next = i_idx + 1'b1;
            end else begin
              j_next = j_idx + 1'b1;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign sum = s2.first ? AccW'(prod) : acc + AccW'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s1       <= '0;
      s2       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      s1    <= issue;
      s2    <= s1;
      if (land) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_idx <= i_next;
    j_idx <= j_next;
    k_idx <= k_next;
    prod  <= $signed(a_rdata) * $signed(b_rdata);
    if (s2.valid) begin
      acc <= sum;
    end
    if (land) begin
      res_row   <= s2.row;
      res_col   <= s2.col;
      res_value <= OutW'(sum);
      res_last  <= s2.last_el;
    end
  end

  assign m_tdata = {(OutDataW-OutW-2*IdxW)'(0), res_value, res_col, res_row};
  assign m_tlast = res_last;

endmodule

// ===== sv/matrix_multiply_engine.sv =====
// top level: configuration registers, front queue and compute back end
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  tdata: elem_row, elem_col, elem_value; tuser: req_type
//  m_*      out  m_tvalid / m_tready  tdata: out_row, out_col, out_value; tlast: last
//  cfg_*    in   cfg_we               cfg_index, cfg_data
//
// a load item goes into its store when popped; a req_type 3 item is dropped at entry
// each C element runs through the single multiply-accumulate pipe (store read, multiply,
// accumulate); a compute item yields rows_a * cols_b of them (0 reads as 1, above 8 as 8)
// the four-entry queue keeps taking items while the back end works or the output stalls, until full
// reset clears the queue, the sequencer and the dimensions to 8; stores are not cleared
module matrix_multiply_engine import mme_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // elem_row[2:0], elem_col[5:3], elem_value[21:6]
  input  logic [1:0]          s_tuser,   // req_type[1:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // out_row[2:0], out_col[5:3], out_value[45:6]
  output logic                m_tlast,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [DimW-1:0]     cfg_data
);

  logic [DimW-1:0] rows_a, inner_len, cols_b;
  dims_t           dims;
  logic            q_valid;
  work_t           q_item;
  logic            q_pop;

  function automatic logic [IdxW-1:0] last_index(input logic [DimW-1:0] v);
    logic [IdxW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > DimW'(MaxDim)) begin
      r = IdxW'(MaxDim - 1);
    end else begin
      r = IdxW'(v - 1'b1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DimW'(MaxDim);
      inner_len <= DimW'(MaxDim);
      cols_b    <= DimW'(MaxDim);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS_A:    rows_a    <= cfg_data;
        CFG_INNER_LEN: inner_len <= cfg_data;
        CFG_COLS_B:    cols_b    <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign dims.n_last = last_index(rows_a);
  assign dims.m_last = last_index(inner_len);
  assign dims.p_last = last_index(cols_b);

  mme_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mme_back u_back (
    .clk      (clk),
    .rst      (rst),
    .dims     (dims),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
